### sv/sorted_wakeup_timer_queue_unit_defines.svh
// Assertion macros shared by the timer queue checker.
`ifndef SORTED_WAKEUP_TIMER_QUEUE_UNIT_DEFINES_SVH
`define SORTED_WAKEUP_TIMER_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("timer queue check failed");

// Next-cycle implication, disabled during reset.
`define SWT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("timer queue check failed");

`endif

### sv/swt_pkg.sv
// Types and constants of the sorted wake-up timer queue.
`timescale 1ns / 1ps

package swt_pkg;

  localparam int Tasks     = 16;
  localparam int MaxWoken  = 16;
  localparam int CntW      = $clog2(MaxWoken);

  typedef enum logic [1:0] {
    OP_SLEEP  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_ALARM  = 2'd2,
    OP_NONE   = 2'd3
  } swt_op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_DUP      = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } swt_status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_POP    = 2'd3
  } swt_cmd_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  task_id;
    logic [63:0] now_time;
    logic [63:0] duration;
  } swt_in_t;

  typedef struct packed {
    logic        woken_valid;
    logic [3:0]  woken_task;
    logic        last;
    logic        alarm_armed;
    logic [63:0] alarm_time;
    swt_status_e status;
  } swt_out_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  task_id;
    logic [63:0] wake;
  } swt_slot_t;

  typedef struct packed {
    swt_cmd_e    cmd;
    logic [3:0]  task_id;
    logic [63:0] wake;
  } swt_ctl_t;

endpackage

### sv/swt_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbours.
`timescale 1ns / 1ps

module swt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swt_pkg::swt_ctl_t ctl_i,
  input  swt_pkg::swt_slot_t left_i,
  input  logic              left_after_i,
  input  logic              left_hit_i,
  input  swt_pkg::swt_slot_t right_i,
  output swt_pkg::swt_slot_t slot_o,
  output swt_pkg::swt_slot_t slot_d_o,
  output logic              after_o,
  output logic              hit_o
);
  import swt_pkg::*;

  swt_slot_t slot_q, slot_d;

  // Entry wakes strictly later than the new one, or slot is empty.
  assign after_o = !slot_q.valid || (slot_q.wake > ctl_i.wake);
  // Matching task here or somewhere to the left.
  assign hit_o   = left_hit_i || (slot_q.valid && (slot_q.task_id == ctl_i.task_id));

  always_comb begin
    slot_d = slot_q;
    case (ctl_i.cmd)
      CMD_INSERT: begin
        if (left_after_i) begin
          slot_d = left_i;
        end else if (after_o) begin
          slot_d = '{valid: 1'b1, task_id: ctl_i.task_id, wake: ctl_i.wake};
        end
      end
      CMD_REMOVE: begin
        if (hit_o) begin
          slot_d = right_i;
        end
      end
      CMD_POP: slot_d = right_i;
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o   = slot_q;
  assign slot_d_o = slot_d;

endmodule

### sv/swt_chain.sv
// Row of queue cells, head at index zero.
`timescale 1ns / 1ps

module swt_chain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swt_pkg::swt_ctl_t  ctl_i,
  output swt_pkg::swt_slot_t head_o,
  output swt_pkg::swt_slot_t second_o,
  output swt_pkg::swt_slot_t head_d_o,
  output logic               full_o,
  output logic               found_o
);
  import swt_pkg::*;

  swt_slot_t slot_q_w [Tasks];
  swt_slot_t slot_d_w [Tasks];
  logic      after_w  [Tasks];
  logic      hit_w    [Tasks];

  for (genvar i = 0; i < Tasks; i++) begin : g_cell
    swt_slot_t left_w, right_w;
    logic      left_after_w, left_hit_w;

    if (i == 0) begin : g_first
      assign left_w       = '0;
      assign left_after_w = 1'b0;
      assign left_hit_w   = 1'b0;
    end else begin : g_mid
      assign left_w       = slot_q_w[i-1];
      assign left_after_w = after_w[i-1];
      assign left_hit_w   = hit_w[i-1];
    end

    if (i == Tasks - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = slot_q_w[i+1];
    end

    swt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_i),
      .left_i       (left_w),
      .left_after_i (left_after_w),
      .left_hit_i   (left_hit_w),
      .right_i      (right_w),
      .slot_o       (slot_q_w[i]),
      .slot_d_o     (slot_d_w[i]),
      .after_o      (after_w[i]),
      .hit_o        (hit_w[i])
    );
  end

  assign head_o   = slot_q_w[0];
  assign second_o = slot_q_w[1];
  assign head_d_o = slot_d_w[0];
  assign full_o   = slot_q_w[Tasks-1].valid;
  assign found_o  = hit_w[Tasks-1];

endmodule

### sv/sorted_wakeup_timer_queue_unit.sv
// Top level of the sorted wake-up timer queue.
`timescale 1ns / 1ps

// Sleep queue of up to Tasks entries held in a row of cells, earliest wake
// time at the head, equal wake times in arrival order. One input beat is
// taken while the unit is idle; the unit then executes it on the cell row.
// Sleep, cancel, yield and the unused operation code give one result beat.
// An alarm gives one result beat per released task (at most sixteen), or
// a single empty result when nothing is due. The sum now plus duration is
// registered at accept, so the cells only compare in the execute cycle.
// A stalled result register holds execution until it frees; in_stall_o
// stays high while an item is in execution. Reset clears every cell at
// once, with no clearing pass.
module sorted_wakeup_timer_queue_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  swt_pkg::swt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output swt_pkg::swt_out_t out_data_o
);
  import swt_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic            state_q, state_d;
  logic [1:0]      op_q;
  logic [3:0]      id_q;
  logic [63:0]     now_q;
  logic [63:0]     wake_q;
  logic            yield_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic     out_valid_q, out_valid_d;
  swt_out_t out_q, out_d;

  swt_ctl_t  ctl;
  swt_slot_t head, second, head_d;
  logic      full, found;

  logic in_acc, out_free, fire, done;
  logic head_due, second_due;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = (state_q == StExec) && out_free;

  // Due means at or before the current time, plain unsigned compare.
  assign head_due   = head.valid && (head.wake <= now_q);
  assign second_due = second.valid && (second.wake <= now_q);

  swt_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .head_o   (head),
    .second_o (second),
    .head_d_o (head_d),
    .full_o   (full),
    .found_o  (found)
  );

  // Execute: pick the cell command and build the result beat.
  always_comb begin
    logic       woken;
    logic [3:0] woken_task;
    logic       last;
    swt_status_e status;

    ctl.cmd     = CMD_HOLD;
    ctl.task_id = id_q;
    ctl.wake    = wake_q;
    woken       = 1'b0;
    woken_task  = '0;
    last        = 1'b1;
    status      = STATUS_OK;

    case (op_q)
      OP_SLEEP: begin
        // Yield first, then duplicate, then fullness.
        if (yield_q) begin
          status = STATUS_OK;
        end else if (found) begin
          status = STATUS_DUP;
        end else if (full) begin
          status = STATUS_FULL;
        end else begin
          ctl.cmd = fire ? CMD_INSERT : CMD_HOLD;
        end
      end
      OP_CANCEL: begin
        if (found) begin
          ctl.cmd = fire ? CMD_REMOVE : CMD_HOLD;
        end else begin
          status = STATUS_NOTFOUND;
        end
      end
      OP_ALARM: begin
        if (head_due) begin
          ctl.cmd    = fire ? CMD_POP : CMD_HOLD;
          woken      = 1'b1;
          woken_task = head.task_id;
          last       = !second_due || (cnt_q == CntW'(MaxWoken - 1));
        end
      end
      default: begin
        status = STATUS_OK;
      end
    endcase

    done = last;

    // Alarm fields show the queue after this beat's change.
    out_d.woken_valid = woken;
    out_d.woken_task  = woken_task;
    out_d.last        = last;
    out_d.alarm_armed = head_d.valid;
    out_d.alarm_time  = head_d.valid ? head_d.wake : '0;
    out_d.status      = status;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (in_acc) begin
      state_d = StExec;
      cnt_d   = '0;
    end
    if (fire) begin
      out_valid_d = 1'b1;
      cnt_d       = cnt_q + CntW'(1);
      if (done) begin
        state_d = StIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the item; register the wrapped wake time ahead of the compare.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= in_data_i.operation;
      id_q    <= in_data_i.task_id;
      now_q   <= in_data_i.now_time;
      wake_q  <= in_data_i.now_time + in_data_i.duration;
      yield_q <= (in_data_i.duration == 64'd0);
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/swt_checker.sv
// Port-level checks of the timer queue and their bind to the top level.
`timescale 1ns / 1ps
`include "sorted_wakeup_timer_queue_unit_defines.svh"

module swt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input swt_pkg::swt_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input swt_pkg::swt_out_t out_data_o
);
  import swt_pkg::*;

  // An accepted beat is in execution on the next cycle.
  `SWT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // Only released tasks can be followed by more beats of the same item.
  `SWT_ASSERT_NOW(a_more_only_woken, out_valid_o && !out_data_o.last,
                  out_data_o.woken_valid)

  // Unarmed alarm reports a zero time.
  `SWT_ASSERT_NOW(a_unarmed_zero, out_valid_o && !out_data_o.alarm_armed,
                  out_data_o.alarm_time == 64'd0)

  // A release always reports success.
  `SWT_ASSERT_NOW(a_woken_ok, out_valid_o && out_data_o.woken_valid,
                  out_data_o.status == STATUS_OK)

endmodule

bind sorted_wakeup_timer_queue_unit swt_checker u_swt_checker (.*);
